// ----- rtl/efe_pkg.sv -----
// Package for the escaped frame encoder: framing byte codes, result sizes
// and the encoded group type shared by the encoder and the top level.
// Depends on nothing.
package efe_pkg;

   localparam logic [7:0] FrameStart  = 8'hAA;
   localparam logic [7:0] FrameEscape = 8'hBB;
   localparam logic [7:0] FrameStop   = 8'hCC;
   localparam logic [7:0] SubStart    = 8'h55;
   localparam logic [7:0] SubEscape   = 8'h44;
   localparam logic [7:0] SubStop     = 8'h33;

   localparam int MaxResults = 5;
   localparam int CountWidth = $clog2(MaxResults + 1);

   typedef logic [CountWidth-1:0] count_type;

   typedef struct packed {
      logic [MaxResults-1:0][7:0] line_bytes;
      count_type                  count;
      logic                       closes_frame;
   } group_type;

endpackage

// ----- rtl/escaped_frame_encoder_core.sv -----
// Top level of the escaped frame encoder: request register, framing state,
// and a result shift register that sends one line byte per cycle while rsp_stall is low.
// Depends on efe_pkg and efe_encode.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_payload_byte, req_ends_packet
//   rsp_      out        rsp_valid/rsp_stall   rsp_line_byte, rsp_frame_done, rsp_run_last
//
// Each request yields one to five line bytes, sent one per cycle from the result
// shift register while rsp_stall is low. A request is held in the request
// register and is encoded as it moves into the result register, which it may
// do in the cycle its predecessor's last byte is taken. Reset closes any open
// frame and clears the sum.
// A stall on the result side holds the current byte and fills the request side.
module escaped_frame_encoder_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_payload_byte,
   input  logic       req_ends_packet,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_line_byte,
   output logic       rsp_frame_done,
   output logic       rsp_run_last
);

   logic                                in_valid_ff, in_valid_in;
   logic [7:0]                          in_byte_ff;
   logic                                in_ends_ff;
   logic                                inside_frame_ff, inside_frame_in;
   logic [7:0]                          running_sum_ff, running_sum_in;
   logic                                out_valid_ff, out_valid_in;
   logic [efe_pkg::MaxResults-1:0][7:0] out_bytes_ff, out_bytes_in;
   efe_pkg::count_type                  out_remain_ff, out_remain_in;
   logic                                out_closes_ff, out_closes_in;

   efe_pkg::group_type group;
   logic               inside_frame_next;
   logic [7:0]         running_sum_next;
   logic               out_take;
   logic               out_last;
   logic               move;
   logic               req_take;

   efe_encode u_encode (
      .payload_byte      (in_byte_ff),
      .ends_packet       (in_ends_ff),
      .inside_frame      (inside_frame_ff),
      .running_sum       (running_sum_ff),
      .group             (group),
      .inside_frame_next (inside_frame_next),
      .running_sum_next  (running_sum_next)
   );

   assign out_last  = out_remain_ff == efe_pkg::count_type'(1);
   assign out_take  = out_valid_ff && !rsp_stall;
   assign move      = in_valid_ff && (!out_valid_ff || (out_take && out_last));
   assign req_stall = in_valid_ff && !move;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid      = out_valid_ff;
   assign rsp_line_byte  = out_bytes_ff[0];
   assign rsp_run_last   = out_last;
   assign rsp_frame_done = out_last && out_closes_ff;

   always_comb begin
      in_valid_in     = in_valid_ff;
      inside_frame_in = inside_frame_ff;
      running_sum_in  = running_sum_ff;
      out_valid_in    = out_valid_ff;
      out_bytes_in    = out_bytes_ff;
      out_remain_in   = out_remain_ff;
      out_closes_in   = out_closes_ff;
      if (move) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end
      if (out_take) begin
         out_bytes_in  = {8'h00, out_bytes_ff[efe_pkg::MaxResults-1:1]};
         out_remain_in = out_remain_ff - efe_pkg::count_type'(1);
         if (out_last) begin
            out_valid_in = 1'b0;
         end
      end
      if (move) begin
         inside_frame_in = inside_frame_next;
         running_sum_in  = running_sum_next;
         out_valid_in    = 1'b1;
         out_bytes_in    = group.line_bytes;
         out_remain_in   = group.count;
         out_closes_in   = group.closes_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         inside_frame_ff <= 1'b0;
         running_sum_ff  <= 8'h00;
         out_valid_ff    <= 1'b0;
         out_remain_ff   <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         inside_frame_ff <= inside_frame_in;
         running_sum_ff  <= running_sum_in;
         out_valid_ff    <= out_valid_in;
         out_remain_ff   <= out_remain_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_payload_byte;
         in_ends_ff <= req_ends_packet;
      end
      out_bytes_ff  <= out_bytes_in;
      out_closes_ff <= out_closes_in;
   end

endmodule

// ----- rtl/efe_encode.sv -----
// Combinational encoder: turns one raw byte into its group of line bytes
// and computes the next framing state. Depends on efe_pkg.
module efe_encode (
   input  logic [7:0]        payload_byte,
   input  logic              ends_packet,
   input  logic              inside_frame,
   input  logic [7:0]        running_sum,
   output efe_pkg::group_type group,
   output logic              inside_frame_next,
   output logic [7:0]        running_sum_next
);

   logic [7:0]          sum_add;
   efe_pkg::count_type  n;

   assign sum_add = running_sum + payload_byte;

   always_comb begin
      group = '0;
      n = '0;
      if (!inside_frame) begin
         group.line_bytes[n] = efe_pkg::FrameStart;
         n = n + efe_pkg::count_type'(1);
      end
      case (payload_byte)
         efe_pkg::FrameStart: begin
            group.line_bytes[n] = efe_pkg::FrameEscape;
            group.line_bytes[n + efe_pkg::count_type'(1)] = efe_pkg::SubStart;
            n = n + efe_pkg::count_type'(2);
         end
         efe_pkg::FrameEscape: begin
            group.line_bytes[n] = efe_pkg::FrameEscape;
            group.line_bytes[n + efe_pkg::count_type'(1)] = efe_pkg::SubEscape;
            n = n + efe_pkg::count_type'(2);
         end
         efe_pkg::FrameStop: begin
            group.line_bytes[n] = efe_pkg::FrameEscape;
            group.line_bytes[n + efe_pkg::count_type'(1)] = efe_pkg::SubStop;
            n = n + efe_pkg::count_type'(2);
         end
         default: begin
            group.line_bytes[n] = payload_byte;
            n = n + efe_pkg::count_type'(1);
         end
      endcase
      if (ends_packet) begin
         group.line_bytes[n] = sum_add;
         group.line_bytes[n + efe_pkg::count_type'(1)] = efe_pkg::FrameStop;
         n = n + efe_pkg::count_type'(2);
      end
      group.count = n;
      group.closes_frame = ends_packet;
   end

   assign inside_frame_next = !ends_packet;
   assign running_sum_next  = ends_packet ? 8'h00 : sum_add;

endmodule
